>>> src/ectk_pkg.sv
// types, constants and helper functions shared by the token classifier modules
`default_nettype none

package ectk_pkg;

    localparam int BYTE_W      = 8;
    localparam int TOK_W       = 16;
    localparam int ACC_W       = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef logic [ACC_W-1:0]  accent_t;
    typedef logic [BYTE_W-1:0] char_t;

    localparam accent_t ACC_NUMBER = 3'd0;
    localparam accent_t ACC_LENGTH = 3'd1;
    localparam accent_t ACC_ANGLE  = 3'd2;
    localparam accent_t ACC_NAME   = 3'd3;
    localparam accent_t ACC_PUNCT  = 3'd4;
    localparam accent_t ACC_NORMAL = 3'd5;
    localparam accent_t ACC_ERROR  = 3'd6;

    localparam char_t CH_ZERO   = 8'h30;
    localparam char_t CH_NINE   = 8'h39;
    localparam char_t CH_LO_A   = 8'h61;
    localparam char_t CH_LO_Z   = 8'h7a;
    localparam char_t CH_UP_A   = 8'h41;
    localparam char_t CH_UP_Z   = 8'h5a;
    localparam char_t CH_UNDER  = 8'h5f;
    localparam char_t CH_SPACE  = 8'h20;
    localparam char_t CH_TAB    = 8'h09;
    localparam char_t CH_CR     = 8'h0d;
    localparam char_t CH_DOT    = 8'h2e;
    localparam char_t CH_LPAREN = 8'h28;
    localparam char_t CH_RPAREN = 8'h29;
    localparam char_t CH_PLUS   = 8'h2b;
    localparam char_t CH_MINUS  = 8'h2d;
    localparam char_t CH_STAR   = 8'h2a;
    localparam char_t CH_SLASH  = 8'h2f;
    localparam char_t CH_EQUAL  = 8'h3d;
    localparam char_t CH_COMMA  = 8'h2c;
    localparam char_t CH_P      = 8'h70;
    localparam char_t CH_G      = 8'h67;

    typedef enum logic [2:0] {
        CL_DIGIT,
        CL_LETTER,
        CL_SPACE,
        CL_DOT,
        CL_PUNCT,
        CL_OTHER
    } char_class_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_NUMBER,
        KIND_WORD,
        KIND_SPACE
    } open_kind_t;

    typedef struct packed {
        char_t text_byte;
        logic  end_of_text;
    } in_item_t;

    typedef struct packed {
        accent_t          accent;
        logic [TOK_W-1:0] token_start;
        logic [TOK_W-1:0] token_size;
        logic             final_token;
        logic             run_last;
    } out_item_t;

    typedef struct packed {
        accent_t          accent;
        logic [TOK_W-1:0] start;
        logic [TOK_W-1:0] length;
        logic             ends_text;
    } tok_t;

    // one queue entry holds every token caused by one input beat
    typedef struct packed {
        tok_t tok0;
        tok_t tok1;
        logic two;
    } entry_t;

    typedef struct packed {
        logic dot;
        logic two_dots;
        logic digit;
        logic bad;
    } num_flags_t;

    function automatic char_class_t classify(char_t c);
        char_class_t cl;
        if (c >= CH_ZERO && c <= CH_NINE)
            cl = CL_DIGIT;
        else if ((c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z)
                 || c == CH_UNDER)
            cl = CL_LETTER;
        else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
            cl = CL_SPACE;
        else if (c == CH_DOT)
            cl = CL_DOT;
        else if (c == CH_LPAREN || c == CH_RPAREN || c == CH_PLUS || c == CH_MINUS
                 || c == CH_STAR || c == CH_SLASH || c == CH_EQUAL || c == CH_COMMA)
            cl = CL_PUNCT;
        else
            cl = CL_OTHER;
        return cl;
    endfunction

    function automatic num_flags_t fold_char(num_flags_t f, char_t c);
        num_flags_t r;
        char_class_t cl;
        r  = f;
        cl = classify(c);
        if (cl == CL_DOT)
        begin
            if (f.dot)
                r.two_dots = 1'b1;
            r.dot = 1'b1;
        end
        else if (cl == CL_DIGIT)
            r.digit = 1'b1;
        else
            r.bad = 1'b1;
        return r;
    endfunction

    function automatic accent_t number_accent(num_flags_t f, char_t last);
        num_flags_t g;
        accent_t    acc;
        g = f;
        if (last == CH_P)
            acc = ACC_LENGTH;
        else if (last == CH_G)
            acc = ACC_ANGLE;
        else
        begin
            g   = fold_char(f, last);
            acc = ACC_NUMBER;
        end
        if (g.bad || g.two_dots || !g.digit)
            acc = ACC_ERROR;
        return acc;
    endfunction

endpackage

`default_nettype wire

>>> src/ectk_front.sv
// front part: classifies each byte, tracks the open token and builds queue entries
`default_nettype none

module ectk_front #(
    parameter int POS_BITS = 16
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_stall,
    input  ectk_pkg::in_item_t in_item,
    input  wire               q_full,
    output logic              q_push,
    output ectk_pkg::entry_t  q_entry
);
    import ectk_pkg::*;

    localparam logic [POS_BITS-1:0] POS_MAX = '1;
    localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

    open_kind_t          kind_reg, kind_next, kind_post;
    logic [POS_BITS-1:0] start_reg, start_next, start_post;
    logic [POS_BITS-1:0] len_reg, len_next, len_post;
    logic [POS_BITS-1:0] pos_reg, pos_next, pos_post;
    num_flags_t          flags_reg, flags_next, flags_post;
    char_t               last_reg, last_next, last_post;

    logic        accept;
    char_t       c;
    char_class_t cl;
    logic        cont;
    logic        close_v, single_v, eot_v;
    tok_t        close_tok, single_tok, eot_tok;
    accent_t     close_acc, eot_acc;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign c        = in_item.text_byte;

    always_comb
    begin
        cl = classify(c);

        unique case (kind_reg)
            KIND_NUMBER: cont = (cl == CL_DIGIT) || (cl == CL_LETTER) || (cl == CL_DOT);
            KIND_WORD:   cont = (cl == CL_DIGIT) || (cl == CL_LETTER);
            KIND_SPACE:  cont = (cl == CL_SPACE);
            default:     cont = 1'b0;
        endcase

        unique case (kind_reg)
            KIND_NUMBER: close_acc = number_accent(flags_reg, last_reg);
            KIND_WORD:   close_acc = ACC_NAME;
            default:     close_acc = ACC_NORMAL;
        endcase

        close_v   = !cont && (kind_reg != KIND_NONE);
        close_tok = '{accent: close_acc, start: TOK_W'(start_reg),
                      length: TOK_W'(len_reg), ends_text: 1'b0};

        kind_post  = kind_reg;
        start_post = start_reg;
        len_post   = len_reg;
        flags_post = flags_reg;
        last_post  = last_reg;
        single_v   = 1'b0;
        single_tok = '{accent: ACC_PUNCT, start: TOK_W'(pos_reg),
                       length: TOK_W'(1), ends_text: 1'b0};

        if (cont)
        begin
            len_post = (len_reg == POS_MAX) ? len_reg : len_reg + POS_ONE;
            if (kind_reg == KIND_NUMBER)
            begin
                flags_post = fold_char(flags_reg, last_reg);
                last_post  = c;
            end
        end
        else
        begin
            kind_post  = KIND_NONE;
            start_post = pos_reg;
            len_post   = POS_ONE;
            flags_post = '0;
            last_post  = '0;
            unique case (cl) inside
                CL_DIGIT, CL_DOT:
                begin
                    kind_post = KIND_NUMBER;
                    last_post = c;
                end
                CL_LETTER: kind_post = KIND_WORD;
                CL_SPACE:  kind_post = KIND_SPACE;
                CL_PUNCT:  single_v = 1'b1;
                default:
                begin
                    single_v          = 1'b1;
                    single_tok.accent = ACC_ERROR;
                end
            endcase
        end

        pos_post = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_ONE;

        // end of text closes whatever is still open after this byte
        unique case (kind_post)
            KIND_NUMBER: eot_acc = number_accent(flags_post, last_post);
            KIND_WORD:   eot_acc = ACC_NAME;
            default:     eot_acc = ACC_NORMAL;
        endcase
        eot_v   = in_item.end_of_text && (kind_post != KIND_NONE);
        eot_tok = '{accent: eot_acc, start: TOK_W'(start_post),
                    length: TOK_W'(len_post), ends_text: 1'b0};

        q_entry.two = close_v && (single_v || eot_v);
        if (close_v)
            q_entry.tok0 = close_tok;
        else if (single_v)
            q_entry.tok0 = single_tok;
        else
            q_entry.tok0 = eot_tok;
        q_entry.tok1 = single_v ? single_tok : eot_tok;
        q_entry.tok0.ends_text = in_item.end_of_text && !q_entry.two;
        q_entry.tok1.ends_text = in_item.end_of_text;

        q_push = accept && (close_v || single_v || eot_v);

        kind_next  = kind_reg;
        start_next = start_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        flags_next = flags_reg;
        last_next  = last_reg;
        if (accept)
        begin
            if (in_item.end_of_text)
            begin
                kind_next  = KIND_NONE;
                start_next = '0;
                len_next   = '0;
                pos_next   = '0;
                flags_next = '0;
                last_next  = '0;
            end
            else
            begin
                kind_next  = kind_post;
                start_next = start_post;
                len_next   = len_post;
                pos_next   = pos_post;
                flags_next = flags_post;
                last_next  = last_post;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= KIND_NONE;
            start_reg <= '0;
            len_reg   <= '0;
            pos_reg   <= '0;
            flags_reg <= '0;
            last_reg  <= '0;
        end
        else
        begin
            kind_reg  <= kind_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            flags_reg <= flags_next;
            last_reg  <= last_next;
        end
    end

endmodule

`default_nettype wire

>>> src/ectk_queue.sv
// short entry queue between the front and the back part
`default_nettype none

module ectk_queue (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  ectk_pkg::entry_t push_entry,
    output logic             full,
    input  wire              pop,
    output logic             empty,
    output ectk_pkg::entry_t head
);
    import ectk_pkg::*;

    entry_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;

    assign full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

>>> src/ectk_back.sv
// back part: splits queue entries into single result beats behind an output register
`default_nettype none

module ectk_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 q_empty,
    input  ectk_pkg::entry_t    q_head,
    output logic                q_pop,
    output logic                out_valid,
    input  wire                 out_stall,
    output ectk_pkg::out_item_t out_item
);
    import ectk_pkg::*;

    logic      sel_reg, sel_next;
    logic      valid_reg, valid_next;
    out_item_t item_reg, item_next;
    logic      load;
    logic      last_of_entry;
    tok_t      tok;

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        load          = !q_empty && (!valid_reg || !out_stall);
        tok           = sel_reg ? q_head.tok1 : q_head.tok0;
        last_of_entry = sel_reg || !q_head.two;
        q_pop         = load && last_of_entry;

        item_next = '{accent: tok.accent, token_start: tok.start,
                      token_size: tok.length, final_token: tok.ends_text,
                      run_last: last_of_entry};

        sel_next   = sel_reg;
        valid_next = valid_reg;
        if (load)
        begin
            sel_next   = !last_of_entry;
            valid_next = 1'b1;
        end
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg   <= sel_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= item_next;
    end

endmodule

`default_nettype wire

>>> src/expression_token_classifier.sv
// top level of the expression token classifier
// path: a token passes through the queue and then the output register after the byte that completes it
// throughput: one byte per cycle in unless the queue is full, one token beat per
//   cycle out unless stalled; a byte that yields two tokens is absorbed by the four-entry queue
// reset: rst_n clears the open token, byte position, queue and output register
`default_nettype none

module expression_token_classifier #(
    parameter int POS_BITS = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  ectk_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  wire                 out_stall,
    output ectk_pkg::out_item_t out_item
);
    import ectk_pkg::*;

    logic   q_push, q_full, q_pop, q_empty;
    entry_t q_entry, q_head;

    ectk_front #(
        .POS_BITS (POS_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    ectk_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    ectk_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

>>> src/ectk_checker.sv
// port-level checks for the token classifier and the bind that attaches them
`default_nettype none

module ectk_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 out_valid,
    input wire                 out_stall,
    input ectk_pkg::out_item_t out_item
);
    import ectk_pkg::*;

    // a stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("output beat changed while stalled");

    // the token that ends the text is always the last one of its byte
    a_final_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.final_token |-> out_item.run_last)
        else $error("final token without run_last");

    a_len_accent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.token_size != '0 && out_item.accent <= ACC_ERROR)
        else $error("bad token length or accent");

    a_punct_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.accent == ACC_PUNCT |-> out_item.token_size == TOK_W'(1))
        else $error("punctuation token longer than one byte");

endmodule

bind expression_token_classifier ectk_checker u_ectk_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

`default_nettype wire

>>> test/classifier_token_check.sv
// predicts the token beats of the classifier from its input beats and compares them
`default_nettype none

module classifier_token_check (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    input  wire                 in_stall,
    input  ectk_pkg::in_item_t  in_item,
    input  wire                 out_valid,
    input  wire                 out_stall,
    input  ectk_pkg::out_item_t out_item,
    output int                  fail_count,
    output int                  tokens_due,
    output int                  tokens_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import ectk_pkg::*;

    localparam int REPORT_CAP = 100;

    typedef logic [TOK_W-1:0] pos_t;

    // lexer state as the block should hold it
    open_kind_t lex_kind;
    pos_t       lex_start;
    pos_t       lex_len;
    pos_t       lex_pos;
    logic       had_dot;
    logic       had_two_dots;
    logic       had_digit;
    logic       had_bad;
    char_t      tail_ch;

    out_item_t  beat_toks[$];
    out_item_t  pending_tokens[$];
    int         mismatches = 0;
    int         compared = 0;

    function automatic char_class_t class_of(char_t c);
        if (c >= "0" && c <= "9")
            return CL_DIGIT;
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_")
            return CL_LETTER;
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
            return CL_SPACE;
        if (c == CH_DOT)
            return CL_DOT;
        case (c) inside
            CH_LPAREN, CH_RPAREN, CH_PLUS, CH_MINUS,
            CH_STAR, CH_SLASH, CH_EQUAL, CH_COMMA:
                return CL_PUNCT;
            default:
                return CL_OTHER;
        endcase
    endfunction

    function automatic pos_t sat_up(pos_t v);
        return (&v) ? v : v + pos_t'(1);
    endfunction

    task automatic clear_lexer();
        lex_kind     = KIND_NONE;
        lex_start    = '0;
        lex_len      = '0;
        lex_pos      = '0;
        had_dot      = 1'b0;
        had_two_dots = 1'b0;
        had_digit    = 1'b0;
        had_bad      = 1'b0;
        tail_ch      = '0;
    endtask

    // the flags cover every byte of the open number except tail_ch
    task automatic fold_tail();
        if (tail_ch == CH_DOT)
        begin
            had_two_dots = had_two_dots | had_dot;
            had_dot      = 1'b1;
        end
        else if (class_of(tail_ch) == CL_DIGIT)
            had_digit = 1'b1;
        else
            had_bad = 1'b1;
    endtask

    task automatic add_token(accent_t acc, pos_t start, pos_t len);
        out_item_t t;
        t.accent      = acc;
        t.token_start = start;
        t.token_size  = len;
        t.final_token = 1'b0;
        t.run_last    = 1'b0;
        beat_toks.push_back(t);
    endtask

    task automatic close_token();
        accent_t acc;
        case (lex_kind)
            KIND_NUMBER:
            begin
                if (tail_ch == CH_P)
                    acc = ACC_LENGTH;
                else if (tail_ch == CH_G)
                    acc = ACC_ANGLE;
                else
                begin
                    fold_tail();
                    acc = ACC_NUMBER;
                end
                if (had_bad || had_two_dots || !had_digit)
                    acc = ACC_ERROR;
                add_token(acc, lex_start, lex_len);
            end
            KIND_WORD:
                add_token(ACC_NAME, lex_start, lex_len);
            KIND_SPACE:
                add_token(ACC_NORMAL, lex_start, lex_len);
            default:
                ;
        endcase
        lex_kind = KIND_NONE;
    endtask

    task automatic open_token(open_kind_t kind, char_t c);
        lex_kind     = kind;
        lex_start    = lex_pos;
        lex_len      = pos_t'(1);
        had_dot      = 1'b0;
        had_two_dots = 1'b0;
        had_digit    = 1'b0;
        had_bad      = 1'b0;
        tail_ch      = (kind == KIND_NUMBER) ? c : '0;
    endtask

    task automatic predict_beat(char_t c, logic eot);
        char_class_t cl;
        logic        grows;
        out_item_t   t;
        cl = class_of(c);
        beat_toks = {};
        case (lex_kind)
            KIND_NUMBER: grows = (cl == CL_DIGIT || cl == CL_LETTER || cl == CL_DOT);
            KIND_WORD:   grows = (cl == CL_DIGIT || cl == CL_LETTER);
            KIND_SPACE:  grows = (cl == CL_SPACE);
            default:     grows = 1'b0;
        endcase
        if (grows)
        begin
            lex_len = sat_up(lex_len);
            if (lex_kind == KIND_NUMBER)
            begin
                fold_tail();
                tail_ch = c;
            end
        end
        else
        begin
            close_token();
            case (cl) inside
                CL_DIGIT, CL_DOT: open_token(KIND_NUMBER, c);
                CL_LETTER:        open_token(KIND_WORD, c);
                CL_SPACE:         open_token(KIND_SPACE, c);
                CL_PUNCT:         add_token(ACC_PUNCT, lex_pos, pos_t'(1));
                default:          add_token(ACC_ERROR, lex_pos, pos_t'(1));
            endcase
        end
        lex_pos = sat_up(lex_pos);
        if (eot)
        begin
            close_token();
            if (beat_toks.size() > 0)
            begin
                t = beat_toks.pop_back();
                t.final_token = 1'b1;
                beat_toks.push_back(t);
            end
            clear_lexer();
        end
        if (beat_toks.size() > 0)
        begin
            t = beat_toks.pop_back();
            t.run_last = 1'b1;
            beat_toks.push_back(t);
        end
        foreach (beat_toks[i])
            pending_tokens.push_back(beat_toks[i]);
    endtask

    task automatic compare_field(string name, pos_t want, pos_t got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    task automatic check_token(out_item_t got);
        out_item_t want;
        if (pending_tokens.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $error("token beat with none expected: accent %0d start %0d length %0d",
                       got.accent, got.token_start, got.token_size);
        end
        else
        begin
            want = pending_tokens.pop_front();
            compared++;
            compare_field("accent", want.accent, got.accent);
            compare_field("token_start", want.token_start, got.token_start);
            compare_field("token_size", want.token_size, got.token_size);
            compare_field("final_token", want.final_token, got.final_token);
            compare_field("run_last", want.run_last, got.run_last);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clear_lexer();
            pending_tokens = {};
        end
        else
        begin
            // an output beat never comes from the input beat of the same edge
            if (out_valid && !out_stall)
                check_token(out_item);
            if (in_valid && !in_stall)
                predict_beat(in_item.text_byte, in_item.end_of_text);
        end
        fail_count     <= mismatches;
        tokens_due     <= pending_tokens.size();
        tokens_checked <= compared;
    end

endmodule

`default_nettype wire

>>> test/tb_top.sv
// stimulus, handshake idling and verdict for the expression token classifier
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ectk_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_BYTES = 1100;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_item_t  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_item;

    int fail_count;
    int tokens_due;
    int tokens_checked;

    int  cycles     = 0;
    int  bytes_sent = 0;
    int  texts_sent = 0;
    int  calm_left  = 0;
    bit  hold_req   = 1'b0;

    char_t text_buf[$];

    string digit_pool  = "0123456789";
    string letter_pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string word_pool   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string punct_pool  = "()+-*/=,";
    string odd_pool    = "!#$%&:;<>?@[]^{|}~";
    string num_head    = ".0123456789";
    string num_junk    = "0123456789..pgpgxE_";

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    expression_token_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    classifier_token_check tok_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_item       (out_item),
        .fail_count     (fail_count),
        .tokens_due     (tokens_due),
        .tokens_checked (tokens_checked)
    );

    always @(posedge clk)
        cycles <= cycles + 1;

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d token beats still due", cycles, tokens_due);
        $display("expression_token_classifier: mismatch");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic char_t pick(string pool);
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    task automatic send_byte(char_t b, logic eot);
        int gap;
        gap = 0;
        if (calm_left > 0)
            calm_left--;
        else if ($urandom_range(0, 99) < 3)
            calm_left = $urandom_range(20, 80);
        else
            gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= {b, eot};
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        bytes_sent++;
    endtask

    task automatic send_text(string s, logic eot_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eot_last && (i == s.len() - 1));
        if (eot_last)
            texts_sent++;
    endtask

    // sender stops until every predicted token beat has been taken
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tokens_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic add_fragment();
        int int_digits;
        int frac_digits;
        bit has_dot;
        case ($urandom_range(0, 9)) inside
            0, 1, 9:
            begin
                // well-formed number, sometimes with a unit suffix
                int_digits  = $urandom_range(0, 4);
                has_dot     = $urandom_range(0, 1);
                frac_digits = has_dot ? $urandom_range(0, 3) : 0;
                if (int_digits + frac_digits == 0)
                    int_digits = 1;
                repeat (int_digits) text_buf.push_back(pick(digit_pool));
                if (has_dot)
                    text_buf.push_back(CH_DOT);
                repeat (frac_digits) text_buf.push_back(pick(digit_pool));
                case ($urandom_range(0, 2))
                    1:       text_buf.push_back(CH_P);
                    2:       text_buf.push_back(CH_G);
                    default: ;
                endcase
            end
            2:
            begin
                text_buf.push_back(pick(num_head));
                repeat ($urandom_range(1, 5)) text_buf.push_back(pick(num_junk));
            end
            3, 4:
            begin
                text_buf.push_back(pick(letter_pool));
                repeat ($urandom_range(0, 6)) text_buf.push_back(pick(word_pool));
            end
            5:
                repeat ($urandom_range(1, 4))
                    text_buf.push_back($urandom_range(0, 1) ? CH_SPACE
                                                           : char_t'($urandom_range(9, 13)));
            6:
                text_buf.push_back(pick(punct_pool));
            7:
                case ($urandom_range(0, 4))
                    0:       text_buf.push_back(char_t'($urandom_range(128, 255)));
                    1:       text_buf.push_back(char_t'($urandom_range(0, 8)));
                    2:       text_buf.push_back(char_t'($urandom_range(14, 31)));
                    3:       text_buf.push_back(8'h7f);
                    default: text_buf.push_back(pick(odd_pool));
                endcase
            default:
                text_buf.push_back(char_t'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic send_random_text();
        bit closes_text;
        text_buf = {};
        repeat ($urandom_range(1, 10)) add_fragment();
        // a text left open runs on into the next one
        closes_text = ($urandom_range(0, 9) != 0);
        foreach (text_buf[i])
            send_byte(text_buf[i], closes_text && (i == text_buf.size() - 1));
        if (closes_text)
            texts_sent++;
    endtask

    // receiver side: random stall with quiet stretches and one long hold-off
    initial
    begin : receiver
        int n;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                n = idle_len();
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
                out_stall <= 1'b0;
                if ($urandom_range(0, 19) == 0)
                    repeat ($urandom_range(30, 150)) @(posedge clk);
                else
                    repeat ($urandom_range(1, 4)) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int target;
        bit paused;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // number with length suffix closed by a bracket: two tokens on one beat
        send_text("1.5p(", 1'b0);
        send_text("a_Z9\t", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        // two dots and an angle suffix
        send_text("..3g,", 1'b0);
        // end of text on a non-ascii byte after an open number
        send_text("9", 1'b0);
        send_byte(8'h80, 1'b1);
        send_text("5", 1'b1);
        // lone dot has no digit
        send_text(". ", 1'b1);
        send_text("x=", 1'b1);
        // end of text on a byte that extends the open number
        send_text("2a", 1'b1);
        drain();

        target = bytes_sent + RANDOM_BYTES;
        paused = 1'b0;
        hold_req = 1'b1;
        while (bytes_sent < target)
        begin
            send_random_text();
            if (!paused && bytes_sent >= target - RANDOM_BYTES / 2)
            begin
                drain();
                paused = 1'b1;
            end
        end
        drain();

        $display("sent %0d bytes in %0d finished texts, with a full drain halfway through",
                 bytes_sent, texts_sent);
        $display("compared %0d token beats under random gaps, stalls and a %0d-cycle hold",
                 tokens_checked, HOLD_CYCLES);
        if (fail_count == 0)
            $display("expression_token_classifier: match");
        else
            $display("expression_token_classifier: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
